@@ rtl/cfg_zero_star_guidance_combine_macros.svh @@
// Assertion helpers used by the top-level RTL. Clock clk, synchronous active-low reset rst_n.
`ifndef CFG_ZERO_STAR_GUIDANCE_COMBINE_MACROS_SVH
`define CFG_ZERO_STAR_GUIDANCE_COMBINE_MACROS_SVH

// Same-cycle implication.
`define CFGZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfgz assertion failed");

// Next-cycle implication.
`define CFGZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfgz assertion failed");

`endif

@@ rtl/cfgz_pkg.sv @@
`timescale 1ns / 1ps
package cfgz_pkg;

  localparam int VEC_LEN_DEF    = 64;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int Q_FRAC  = 12;
  localparam int ACC_W   = 48;
  localparam int MID_W   = 48;
  localparam int HALF_W  = MID_W / 2;
  localparam int SCALE_W = 24;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = ACC_W + Q_FRAC;
  localparam int DEN_W   = ACC_W + 1;
  localparam int TOT_W   = 65;
  localparam int RND_SH  = 24;

  localparam int RATE_W = 15;
  localparam int EPS_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GUIDANCE_RATE = 2'd0,
    REG_ZERO_STAR     = 2'd1,
    REG_EPS_BIAS      = 2'd2
  } cfg_reg_t;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(8192);
  localparam logic              ZSE_RST  = 1'b1;
  localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(1);

  localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(4096);
  localparam logic signed [SCALE_W-1:0] SCALE_MAX = {1'b0, {(SCALE_W-1){1'b1}}};
  localparam logic signed [SCALE_W-1:0] SCALE_MIN = {1'b1, {(SCALE_W-1){1'b0}}};

  localparam logic signed [MID_W:0] MID_MAX = {2'b00, {(MID_W-1){1'b1}}};
  localparam logic signed [MID_W:0] MID_MIN = -MID_MAX;

endpackage

@@ rtl/cfgz_in_if.sv @@
`timescale 1ns / 1ps
interface cfgz_in_if import cfgz_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] cond_value;
  logic signed [DATA_WIDTH-1:0] uncond_value;
  logic                         last_element;

  modport source (output valid, cond_value, uncond_value, last_element, input ready);
  modport sink   (input valid, cond_value, uncond_value, last_element, output ready);
endinterface

@@ rtl/cfgz_out_if.sv @@
`timescale 1ns / 1ps
interface cfgz_out_if import cfgz_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] guided_value;
  logic                         last_result;

  modport source (output valid, guided_value, last_result, input ready);
  modport sink   (input valid, guided_value, last_result, output ready);
endinterface

@@ rtl/cfgz_cfg_if.sv @@
`timescale 1ns / 1ps
interface cfgz_cfg_if import cfgz_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cfgz_ram.sv @@
`timescale 1ns / 1ps
module cfgz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/cfgz_mul.sv @@
`timescale 1ns / 1ps
module cfgz_mul import cfgz_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/cfgz_div.sv @@
`timescale 1ns / 1ps
module cfgz_div import cfgz_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  input  logic                      neg,
  output logic                      done,
  output logic signed [SCALE_W-1:0] scale
);

  localparam int STEP_W = $clog2(NUM_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t                    st_r;
  logic [STEP_W-1:0]          step_r;
  logic [NUM_W-1:0]           num_r;
  logic [DEN_W-1:0]           den_r;
  logic [DEN_W-1:0]           rem_r;
  logic [SCALE_W-1:0]         q_r;
  logic                       ovf_r;
  logic                       neg_r;
  logic                       done_r;
  logic signed [SCALE_W-1:0]  scale_r;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_sub;
  logic           ge;
  logic           big;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign big     = ovf_r | q_r[SCALE_W-1];

  assign done  = done_r;
  assign scale = scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            num_r  <= num;
            den_r  <= den;
            neg_r  <= neg;
            rem_r  <= '0;
            q_r    <= '0;
            ovf_r  <= 1'b0;
            step_r <= STEP_W'(NUM_W - 1);
            st_r   <= (den == '0) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          num_r <= num_r << 1;
          q_r   <= {q_r[SCALE_W-2:0], ge};
          ovf_r <= ovf_r | q_r[SCALE_W-1];
          if (step_r == '0) begin
            st_r <= D_FIN;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        D_FIN: begin
          done_r <= 1'b1;
          if (neg_r) begin
            scale_r <= big ? SCALE_MIN : -$signed(q_r);
          end else begin
            scale_r <= big ? SCALE_MAX : $signed(q_r);
          end
          st_r <= D_IDLE;
        end
        default: begin
          st_r <= D_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/cfg_zero_star_guidance_combine.sv @@
`timescale 1ns / 1ps
// Load: a request steps S_LOAD, S_UU, S_NRM (c*u then u*u via the shared multiplier).
// Scale: 60-step bit-serial divider with zero-star on, unit scale with it off.
// Burst: each result steps S_RD to S_OUT, with multiplier passes s*u, rate*d low/high.
// Input is held off from the last request until the final result is registered.
// rst_n (sync, active low) clears count, accumulators, out valid; presets config regs.
module cfg_zero_star_guidance_combine import cfgz_pkg::*; #(
  parameter int VEC_LEN    = VEC_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cfgz_in_if.sink    in_ch,
  cfgz_out_if.source out_ch,
  cfgz_cfg_if.sink   cfg_ch
);

`include "cfg_zero_star_guidance_combine_macros.svh"

  localparam int AW    = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int CNT_W = $clog2(VEC_LEN + 1);
  localparam int G_W   = TOT_W - RND_SH;
  localparam logic signed [G_W-1:0] G_HI =
    {{(G_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [G_W-1:0] G_LO = ~G_HI;

  typedef enum logic [3:0] {
    S_LOAD, S_UU, S_NRM, S_SCALE, S_DIVW, S_RD, S_SU,
    S_SCL, S_DIF, S_ML, S_MH, S_FIN, S_OUT
  } state_t;

  state_t                       state_r;
  logic [RATE_W-1:0]            rate_r;
  logic                         zse_r;
  logic [EPS_W-1:0]             eps_r;
  logic [ACC_W-1:0]             dot_r;
  logic [ACC_W-1:0]             norm_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             idx_r;
  logic                         last_r;
  logic signed [DATA_WIDTH-1:0] u_r;
  logic signed [DATA_WIDTH-1:0] c_r;
  logic signed [SCALE_W-1:0]    scale_r;
  logic signed [MID_W-1:0]      su_r;
  logic signed [MID_W-1:0]      d_r;
  logic signed [TOT_W-1:0]      tot_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] guided_r;
  logic                         out_last_r;

  logic                         in_acc;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic [2*DATA_WIDTH-1:0]      rd_data;
  logic signed [DATA_WIDTH-1:0] rd_c;
  logic signed [DATA_WIDTH-1:0] rd_u;
  logic signed [MID_W-1:0]      su_nxt;
  logic signed [MID_W:0]        c_sh;
  logic signed [MID_W:0]        diff;
  logic signed [MID_W-1:0]      d_nxt;
  logic signed [TOT_W-1:0]      rnd;
  logic signed [G_W-1:0]        g;
  logic signed [DATA_WIDTH-1:0] g_sat;
  logic                         out_load;
  logic                         burst_end;
  logic                         div_start;
  logic                         div_done;
  logic signed [SCALE_W-1:0]    div_scale;
  logic [ACC_W-1:0]             dot_mag;
  logic [DEN_W-1:0]             den;

  assign in_ch.ready  = (state_r == S_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.guided_value = guided_r;
  assign out_ch.last_result  = out_last_r;

  cfgz_ram #(
    .WIDTH (2 * DATA_WIDTH),
    .DEPTH (VEC_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({in_ch.cond_value, in_ch.uncond_value}),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_c = rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
  assign rd_u = rd_data[DATA_WIDTH-1:0];

  always_comb begin
    case (state_r)
      S_LOAD: begin
        mul_a = MUL_W'(in_ch.cond_value);
        mul_b = MUL_W'(in_ch.uncond_value);
      end
      S_UU: begin
        mul_a = MUL_W'(u_r);
        mul_b = MUL_W'(u_r);
      end
      S_SU: begin
        mul_a = MUL_W'(scale_r);
        mul_b = MUL_W'(rd_u);
      end
      S_ML: begin
        mul_a = MUL_W'(rate_r);
        mul_b = MUL_W'(d_r[HALF_W-1:0]);
      end
      S_MH: begin
        mul_a = MUL_W'(rate_r);
        mul_b = MUL_W'($signed(d_r[MID_W-1:HALF_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cfgz_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign dot_mag = dot_r[ACC_W-1] ? (~dot_r + 1'b1) : dot_r;
  assign den     = DEN_W'(norm_r) + DEN_W'(eps_r);

  assign div_start = (state_r == S_SCALE) && zse_r;

  cfgz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({dot_mag, {Q_FRAC{1'b0}}}),
    .den   (den),
    .neg   (dot_r[ACC_W-1]),
    .done  (div_done),
    .scale (div_scale)
  );

  always_comb begin
    if (mul_p > PROD_W'(MID_MAX)) begin
      su_nxt = MID_MAX[MID_W-1:0];
    end else if (mul_p < PROD_W'(MID_MIN)) begin
      su_nxt = MID_MIN[MID_W-1:0];
    end else begin
      su_nxt = mul_p[MID_W-1:0];
    end

    c_sh = (MID_W+1)'(c_r) <<< Q_FRAC;
    diff = c_sh - (MID_W+1)'(su_r);
    if (diff > MID_MAX) begin
      d_nxt = MID_MAX[MID_W-1:0];
    end else if (diff < MID_MIN) begin
      d_nxt = MID_MIN[MID_W-1:0];
    end else begin
      d_nxt = diff[MID_W-1:0];
    end

    rnd = tot_r + (TOT_W'(1) <<< (RND_SH - 1));
    g   = rnd[TOT_W-1:RND_SH];
    if (g > G_HI) begin
      g_sat = G_HI[DATA_WIDTH-1:0];
    end else if (g < G_LO) begin
      g_sat = G_LO[DATA_WIDTH-1:0];
    end else begin
      g_sat = g[DATA_WIDTH-1:0];
    end
  end

  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign burst_end = (CNT_W'(idx_r + 1'b1) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      rate_r      <= RATE_RST;
      zse_r       <= ZSE_RST;
      eps_r       <= EPS_RST;
      dot_r       <= '0;
      norm_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_GUIDANCE_RATE: rate_r <= cfg_ch.data[RATE_W-1:0];
          REG_ZERO_STAR:     zse_r  <= cfg_ch.data[0];
          REG_EPS_BIAS:      eps_r  <= cfg_ch.data[EPS_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            u_r     <= in_ch.uncond_value;
            last_r  <= in_ch.last_element;
            state_r <= S_UU;
          end
        end
        S_UU: begin
          dot_r   <= dot_r + mul_p[ACC_W-1:0];
          state_r <= S_NRM;
        end
        S_NRM: begin
          norm_r <= norm_r + mul_p[ACC_W-1:0];
          cnt_r  <= cnt_r + 1'b1;
          idx_r  <= '0;
          if (last_r || cnt_r == CNT_W'(VEC_LEN - 1)) begin
            state_r <= S_SCALE;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_SCALE: begin
          if (zse_r) begin
            state_r <= S_DIVW;
          end else begin
            scale_r <= SCALE_ONE;
            state_r <= S_RD;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            scale_r <= div_scale;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_SU;
        end
        S_SU: begin
          c_r     <= rd_c;
          state_r <= S_SCL;
        end
        S_SCL: begin
          su_r    <= su_nxt;
          state_r <= S_DIF;
        end
        S_DIF: begin
          d_r     <= d_nxt;
          state_r <= S_ML;
        end
        S_ML: begin
          state_r <= S_MH;
        end
        S_MH: begin
          tot_r   <= (TOT_W'(su_r) <<< Q_FRAC) + TOT_W'(mul_p);
          state_r <= S_FIN;
        end
        S_FIN: begin
          tot_r   <= tot_r + (TOT_W'(mul_p) <<< HALF_W);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            guided_r    <= g_sat;
            out_last_r  <= burst_end;
            if (burst_end) begin
              cnt_r   <= '0;
              dot_r   <= '0;
              norm_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  `CFGZ_ASSERT_IMP(a_load_room, in_ch.ready, cnt_r < CNT_W'(VEC_LEN))
  `CFGZ_ASSERT_IMP(a_div_done_wait, div_done, state_r == S_DIVW)
  `CFGZ_ASSERT_IMP(a_idx_range, state_r == S_RD || state_r == S_OUT, idx_r < cnt_r)
  `CFGZ_ASSERT_NXT(a_burst_clear, out_load && burst_end,
                   cnt_r == '0 && dot_r == '0 && norm_r == '0 && state_r == S_LOAD)

endmodule

@@ test/cfg_zero_star_guidance_combine_test.sv @@
`timescale 1ns / 1ps
module cfg_zero_star_guidance_combine_test;
  import cfgz_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int VLEN = VEC_LEN_DEF;
  localparam longint MID_LIM = 64'sd140737488355327;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PAIRS = 230;

  typedef struct {
    logic signed [DW-1:0] cond;
    logic signed [DW-1:0] uncond;
    logic                 last;
  } pair_req_t;

  typedef struct {
    logic signed [DW-1:0] guided;
    logic                 last;
  } guided_t;

  typedef struct {
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cfgz_in_if #(.DATA_WIDTH(DW)) in_ch ();
  cfgz_out_if #(.DATA_WIDTH(DW)) out_ch ();
  cfgz_cfg_if cfg_ch ();

  cfg_zero_star_guidance_combine #(.VEC_LEN(VLEN), .DATA_WIDTH(DW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [RATE_W-1:0]    rate_q = RATE_RST;
  logic                 zs_en = ZSE_RST;
  logic [EPS_W-1:0]     eps_val = EPS_RST;
  logic signed [DW-1:0] cond_mem [VLEN];
  logic signed [DW-1:0] uncond_mem [VLEN];
  logic [ACC_W-1:0]     dot_acc = '0;
  logic [ACC_W-1:0]     norm_acc = '0;
  int                   elem_cnt = 0;

  pair_req_t  pair_queue [$];
  guided_t    guided_expect [$];
  reg_write_t reg_queue [$];
  int pairs_queued = 0;
  int pairs_taken = 0;
  int regs_queued = 0;
  int regs_taken = 0;
  int bad_results = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  pair_req_t  next_pair;
  reg_write_t next_reg;
  guided_t    want;

  function automatic longint clip(longint x, longint lo, longint hi);
    clip = x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 55) pick_gap = 0;
    else if (r < 85) pick_gap = $urandom_range(1, 3);
    else if (r < 97) pick_gap = $urandom_range(4, 12);
    else pick_gap = $urandom_range(20, 60);
  endfunction

  task automatic predict_guided(input logic signed [DW-1:0] c, input logic signed [DW-1:0] u,
                                input logic last);
    longint cv, uv, dot, den, scale, su, diff, total, g, rv;
    logic signed [ACC_W-1:0] dot_w;
    guided_t res;
    int n;
    cv = c;
    uv = u;
    if (elem_cnt >= VLEN) elem_cnt = 0;
    cond_mem[elem_cnt] = c;
    uncond_mem[elem_cnt] = u;
    dot_acc = dot_acc + ACC_W'(cv * uv);
    norm_acc = norm_acc + ACC_W'(uv * uv);
    elem_cnt++;
    if (!last && elem_cnt < VLEN) return;

    if (!zs_en) begin
      scale = 4096;
    end else begin
      dot_w = dot_acc;
      dot = dot_w;
      den = norm_acc;
      den = den + eps_val;
      if (den == 0) scale = 0;
      else scale = clip((dot * 4096) / den, -64'sd8388608, 64'sd8388607);
    end
    rv = rate_q;
    n = elem_cnt;
    for (int i = 0; i < n; i++) begin
      cv = cond_mem[i];
      uv = uncond_mem[i];
      su = clip(scale * uv, -MID_LIM, MID_LIM);
      diff = clip(cv * 4096 - su, -MID_LIM, MID_LIM);
      total = su * 4096 + rv * diff;
      g = clip((total + (64'sd1 <<< 23)) >>> 24, -64'sd32768, 64'sd32767);
      res.guided = DW'(g);
      res.last = (i == n - 1);
      guided_expect.push_back(res);
    end
    dot_acc = '0;
    norm_acc = '0;
    elem_cnt = 0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_guided(in_ch.cond_value, in_ch.uncond_value, in_ch.last_element);
      pairs_taken++;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        next_pair = pair_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cond_value <= next_pair.cond;
        in_ch.uncond_value <= next_pair.uncond;
        in_ch.last_element <= next_pair.last;
        in_gap = pick_gap(in_idle_on);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // register writes
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_GUIDANCE_RATE: rate_q = cfg_ch.data[RATE_W-1:0];
        REG_ZERO_STAR:     zs_en = cfg_ch.data[0];
        REG_EPS_BIAS:      eps_val = cfg_ch.data[EPS_W-1:0];
        default: ;
      endcase
      regs_taken++;
    end
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else if (!cfg_ch.valid || cfg_ch.ready) begin
      if (reg_queue.size() > 0) begin
        next_reg = reg_queue.pop_front();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= next_reg.idx;
        cfg_ch.data <= next_reg.data;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and ready driver
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (guided_expect.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: guided=%0d last=%0b",
                   out_ch.guided_value, out_ch.last_result);
      end else begin
        want = guided_expect.pop_front();
        if (out_ch.guided_value !== want.guided || out_ch.last_result !== want.last) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected guided=%0d last=%0b, got guided=%0d last=%0b",
                     want.guided, want.last, out_ch.guided_value, out_ch.last_result);
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_stall = pick_gap(out_idle_on);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_value(int style);
    int v;
    case (style)
      0: begin
        v = $urandom;
      end
      1: begin
        v = $urandom_range(0, 4095);
        v = v - 2048;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 4096;
        endcase
      end
    endcase
    pick_value = DW'(v);
  endfunction

  task automatic push_pair(input logic signed [DW-1:0] c, input logic signed [DW-1:0] u,
                           input logic last);
    pair_req_t p;
    p.cond = c;
    p.uncond = u;
    p.last = last;
    pair_queue.push_back(p);
    pairs_queued++;
  endtask

  task automatic queue_vector(input int n);
    int style, s;
    logic last;
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      s = (style == 3) ? $urandom_range(0, 2) : (style == 0 ? 0 : style - 1);
      last = (i == n - 1) ? ((n < VLEN) ? 1'b1 : 1'($urandom_range(0, 1))) : 1'b0;
      push_pair(pick_value(s), pick_value(s), last);
    end
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] rate, input logic zs,
                            input logic [CFG_DATA_W-1:0] eps);
    reg_write_t w;
    w.idx = REG_GUIDANCE_RATE;
    w.data = rate;
    reg_queue.push_back(w);
    w.idx = REG_ZERO_STAR;
    w.data = CFG_DATA_W'(zs);
    reg_queue.push_back(w);
    w.idx = REG_EPS_BIAS;
    w.data = eps;
    reg_queue.push_back(w);
    regs_queued += 3;
    while (regs_taken != regs_queued) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pairs_taken != pairs_queued || guided_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_pairs, phase_pairs, n, r;
    logic [CFG_DATA_W-1:0] rate, eps;
    in_ch.valid = 1'b0;
    in_ch.cond_value = '0;
    in_ch.uncond_value = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: rate 2.0, zero-star on
    push_pair(32767, 32767, 1'b1);
    push_pair(-32768, -32768, 1'b0);
    push_pair(-32768, 32767, 1'b1);
    push_pair(0, 0, 1'b1);
    push_pair(4096, -4096, 1'b0);
    push_pair(-1, 1, 1'b0);
    push_pair(12345, -23456, 1'b1);
    wait_drained();

    // max rate, unit scale: saturation both ways
    write_regs(16'h7fff, 1'b0, 16'hffff);
    push_pair(32767, -32768, 1'b0);
    push_pair(-32768, 32767, 1'b1);
    push_pair(1, 0, 1'b1);
    wait_drained();

    // zero divisor with all-zero uncond, then rate of zero
    write_regs(16'h0000, 1'b1, 16'h0000);
    push_pair(1000, 0, 1'b0);
    push_pair(-5, 0, 1'b1);
    push_pair(20000, -7000, 1'b0);
    push_pair(-300, 9000, 1'b1);
    wait_drained();

    random_pairs = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      r = $urandom_range(0, 4);
      rate = (r == 0) ? 16'd0 : (r == 1) ? 16'd32767 : (r == 2) ? 16'd4096 :
             CFG_DATA_W'($urandom_range(0, 32767));
      r = $urandom_range(0, 3);
      eps = (r == 0) ? 16'd1 : (r == 1) ? 16'd65535 : CFG_DATA_W'($urandom_range(1, 65535));
      write_regs(rate, 1'($urandom_range(0, 1)), eps);
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      phase_pairs = 0;
      while (phase_pairs < 40) begin
        r = $urandom_range(0, 99);
        if (r < 65) n = $urandom_range(1, 8);
        else if (r < 85) n = $urandom_range(9, 32);
        else if (r < 95) n = VLEN;
        else n = $urandom_range(33, VLEN - 1);
        queue_vector(n);
        phase_pairs += n;
      end
      random_pairs += phase_pairs;
      wait_drained();
    end

    if (bad_results == 0 && guided_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cfgz_pkg.sv
rtl/cfgz_in_if.sv
rtl/cfgz_out_if.sv
rtl/cfgz_cfg_if.sv
rtl/cfgz_ram.sv
rtl/cfgz_mul.sv
rtl/cfgz_div.sv
rtl/cfg_zero_star_guidance_combine.sv
test/cfg_zero_star_guidance_combine_test.sv
